/* sv/wall_column_texel_mapper_top_defines.svh */
// Assertion macros for the wall column texel mapper.
`ifndef WALL_COLUMN_TEXEL_MAPPER_TOP_DEFINES_SVH
`define WALL_COLUMN_TEXEL_MAPPER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define WCM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define WCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/wcm_pkg.sv */
// Shared types and constants for the wall column texel mapper.
`default_nettype none

package wcm_pkg;

   localparam int TEX_W   = 11;
   localparam int FRAME_W = 19;
   localparam int TEXEL_W = 20;
   localparam int QBITS   = 19;
   localparam int REM_W   = 36;
   localparam int HDIV_W  = 16;
   localparam int D_W     = 26;
   localparam int N_W     = 37;

   typedef enum logic {
      CSR_TEXTURE_WIDTH  = 1'b0,
      CSR_TEXTURE_HEIGHT = 1'b1
   } wcm_csr_type;

   typedef struct packed {
      logic               valid;
      logic               wr;
      logic               neg;
      logic               sat;
      logic [REM_W-1:0]   rem;
      logic [HDIV_W-1:0]  div;
      logic [QBITS-1:0]   q;
      logic [TEX_W-1:0]   col;
      logic [FRAME_W-1:0] frame;
   } wcm_div_type;

   typedef struct packed {
      logic               valid;
      logic               write_pixel;
      logic [FRAME_W-1:0] frame_index;
      logic [TEXEL_W-1:0] texel_index;
   } wcm_rsp_type;

endpackage

`default_nettype wire

/* sv/wall_column_texel_mapper_top.sv */
// Top level of the wall column texel mapper: configuration, pipeline and output skid.
`default_nettype none
`include "wall_column_texel_mapper_top_defines.svh"

// Maps one pixel of a raycast wall column to its frame index and texel index.
// One pixel is accepted per clock while req_stall is low; rsp_valid for a pixel
// rises once it has passed the front stages, the 19-stage quotient pipeline that
// forms the texture row and the back stages. The output register is backed by a
// one-entry skid stage; req_stall rises only when that skid stage is occupied,
// and while it is high the whole pipeline holds. texture_width and
// texture_height are written through the csr_ port, which is always ready;
// the user writes them only once the block has drained, which it does not enforce.

module wall_column_texel_mapper_top import wcm_pkg::*; #(
   parameter int SCREEN_W = 640,
   parameter int SCREEN_H = 480
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [11:0]        req_pixel_x,
   input  wire logic [15:0]        req_pixel_y,
   input  wire logic [15:0]        req_wall_top,
   input  wire logic [15:0]        req_wall_bottom,
   input  wire logic               req_hit_side,
   input  wire logic [31:0]        req_ray_origin_x,
   input  wire logic [31:0]        req_ray_origin_y,
   input  wire logic [31:0]        req_ray_step_x,
   input  wire logic [31:0]        req_ray_step_y,
   input  wire logic [30:0]        req_wall_distance,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_write_pixel,
   output      logic [FRAME_W-1:0] rsp_frame_index,
   output      logic [TEXEL_W-1:0] rsp_texel_index,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic               csr_index,
   input  wire logic [TEX_W-1:0]   csr_data
);

   logic [TEX_W-1:0] tex_width_ff, tex_width_in;
   logic [TEX_W-1:0] tex_height_ff, tex_height_in;

   wcm_rsp_type out_ff, out_in;
   wcm_rsp_type skid_ff, skid_in;

   wcm_div_type front_s;
   wcm_div_type div_s;
   wcm_rsp_type result_s;

   logic ce;
   logic take;
   logic incoming;

   assign csr_ready = 1'b1;

   always_comb begin
      tex_width_in  = tex_width_ff;
      tex_height_in = tex_height_ff;
      if (csr_valid && csr_ready) begin
         case (wcm_csr_type'(csr_index))
            CSR_TEXTURE_WIDTH:  tex_width_in  = csr_data;
            CSR_TEXTURE_HEIGHT: tex_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= 11'd64;
         tex_height_ff <= 11'd64;
      end else begin
         tex_width_ff  <= tex_width_in;
         tex_height_ff <= tex_height_in;
      end
   end

   assign ce        = !skid_ff.valid;
   assign req_stall = skid_ff.valid;

   wcm_front #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .ce            (ce),
      .in_valid      (req_valid),
      .pixel_x       (req_pixel_x),
      .pixel_y       (req_pixel_y),
      .wall_top      (req_wall_top),
      .wall_bottom   (req_wall_bottom),
      .hit_side      (req_hit_side),
      .ray_origin_x  (req_ray_origin_x),
      .ray_origin_y  (req_ray_origin_y),
      .ray_step_x    (req_ray_step_x),
      .ray_step_y    (req_ray_step_y),
      .wall_distance (req_wall_distance),
      .tex_width     (tex_width_ff),
      .tex_height    (tex_height_ff),
      .div_out       (front_s)
   );

   wcm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ce      (ce),
      .div_in  (front_s),
      .div_out (div_s)
   );

   wcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ce         (ce),
      .tex_width  (tex_width_ff),
      .tex_height (tex_height_ff),
      .div_in     (div_s),
      .result     (result_s)
   );

   assign take     = out_ff.valid && !rsp_stall;
   assign incoming = result_s.valid && ce;

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (skid_ff.valid) begin
         if (take) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end
      end else if (incoming) begin
         if (!out_ff.valid || take) begin
            out_in = result_s;
         end else begin
            skid_in = result_s;
         end
      end else if (take) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff  <= '0;
         skid_ff <= '0;
      end else begin
         out_ff  <= out_in;
         skid_ff <= skid_in;
      end
   end

   assign rsp_valid       = out_ff.valid;
   assign rsp_write_pixel = out_ff.write_pixel;
   assign rsp_frame_index = out_ff.frame_index;
   assign rsp_texel_index = out_ff.texel_index;

   `WCM_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_ff.valid, out_ff.valid, "skid holds a transfer while the output register is empty")
   `WCM_ASSERT_NOW(a_stall_from_sink, clock, reset, req_stall, $past(rsp_stall), "request side stalled without a stall on the response side")
   `WCM_ASSERT_NEXT(a_skid_kept, clock, reset, skid_ff.valid && rsp_stall, req_stall, "skid entry dropped while the response side stalls")
   `WCM_ASSERT_NOW(a_no_write_zero, clock, reset, rsp_valid && !rsp_write_pixel, (rsp_frame_index == '0) && (rsp_texel_index == '0), "indices not cleared for a pixel that is not written")

endmodule

`default_nettype wire

/* sv/wcm_front.sv */
// Front stages: ray hit fraction, texture column, row numerator and divider set-up.
`default_nettype none

module wcm_front import wcm_pkg::*; #(
   parameter int SCREEN_W = 640,
   parameter int SCREEN_H = 480
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               ce,
   input  wire logic               in_valid,
   input  wire logic [11:0]        pixel_x,
   input  wire logic [15:0]        pixel_y,
   input  wire logic [15:0]        wall_top,
   input  wire logic [15:0]        wall_bottom,
   input  wire logic               hit_side,
   input  wire logic [31:0]        ray_origin_x,
   input  wire logic [31:0]        ray_origin_y,
   input  wire logic [31:0]        ray_step_x,
   input  wire logic [31:0]        ray_step_y,
   input  wire logic [30:0]        wall_distance,
   input  wire logic [TEX_W-1:0]   tex_width,
   input  wire logic [TEX_W-1:0]   tex_height,
   output wcm_div_type             div_out
);

   localparam int RowBits = $clog2(SCREEN_H);
   localparam int ColBits = $clog2(SCREEN_W);
   localparam int SwBits  = $clog2(SCREEN_W + 1);
   localparam int SumBits = (RowBits + SwBits + 1 > FRAME_W) ? RowBits + SwBits + 1 : FRAME_W;
   localparam logic [D_W-1:0] HalfScreen = D_W'(SCREEN_H * 128);

   typedef struct packed {
      logic        valid;
      logic        wr;
      logic        flip;
      logic [15:0] org;
      logic [31:0] prod;
      logic [16:0] h;
      logic [15:0] py;
      logic [11:0] px;
   } f1_type;

   typedef struct packed {
      logic               valid;
      logic               wr;
      logic               flip;
      logic [31:0]        frac;
      logic [D_W-1:0]     d;
      logic [16:0]        h;
      logic [FRAME_W-1:0] frame;
   } f2_type;

   typedef struct packed {
      logic               valid;
      logic               wr;
      logic               flip;
      logic [42:0]        colprod;
      logic [N_W-1:0]     n;
      logic [16:0]        h;
      logic [FRAME_W-1:0] frame;
   } f3_type;

   typedef struct packed {
      logic               valid;
      logic               wr;
      logic               neg;
      logic [TEX_W-1:0]   col;
      logic [REM_W-1:0]   a;
      logic [HDIV_W-1:0]  b;
      logic [FRAME_W-1:0] frame;
   } f4_type;

   f1_type      f1_ff, f1_in;
   f2_type      f2_ff, f2_in;
   f3_type      f3_ff, f3_in;
   f4_type      f4_ff, f4_in;
   wcm_div_type f5_ff, f5_in;

   logic [16:0]            height;
   logic                   on_screen;
   logic [SumBits-1:0]     frame_sum;
   logic signed [N_W-1:0]  n_prod;
   logic [N_W-1:0]         n_neg;
   logic [TEX_W-1:0]       col_raw;

   always_comb begin
      height    = {wall_bottom[15], wall_bottom} - {wall_top[15], wall_top};
      on_screen = !pixel_y[15] && (pixel_y < 16'(SCREEN_H))
                  && !pixel_x[11] && (pixel_x < 12'(SCREEN_W));
      f1_in.valid = in_valid;
      f1_in.wr    = on_screen && (height != 17'd0);
      f1_in.flip  = hit_side ? ray_step_x[31] : (!ray_step_y[31] && (ray_step_y != 32'd0));
      f1_in.org   = hit_side ? ray_origin_x[15:0] : ray_origin_y[15:0];
      f1_in.prod  = 32'(wall_distance) * (hit_side ? ray_step_x : ray_step_y);
      f1_in.h     = height;
      f1_in.py    = pixel_y;
      f1_in.px    = pixel_x;
   end

   always_comb begin
      frame_sum   = SumBits'(f1_ff.py[RowBits-1:0]) * SumBits'(SCREEN_W)
                    + SumBits'(f1_ff.px[ColBits-1:0]);
      f2_in.valid = f1_ff.valid;
      f2_in.wr    = f1_ff.wr;
      f2_in.flip  = f1_ff.flip;
      f2_in.frac  = {f1_ff.org, 16'd0} + f1_ff.prod;
      f2_in.d     = {{2{f1_ff.py[15]}}, f1_ff.py, 8'd0} - HalfScreen
                    + {{2{f1_ff.h[16]}}, f1_ff.h, 7'd0};
      f2_in.h     = f1_ff.h;
      f2_in.frame = f1_ff.wr ? frame_sum[FRAME_W-1:0] : '0;
   end

   always_comb begin
      n_prod        = $signed(f2_ff.d) * $signed({1'b0, tex_height});
      f3_in.valid   = f2_ff.valid;
      f3_in.wr      = f2_ff.wr;
      f3_in.flip    = f2_ff.flip;
      f3_in.colprod = 43'(f2_ff.frac) * 43'(tex_width);
      f3_in.n       = n_prod;
      f3_in.h       = f2_ff.h;
      f3_in.frame   = f2_ff.frame;
   end

   always_comb begin
      col_raw     = f3_ff.colprod[42:32];
      n_neg       = -f3_ff.n;
      f4_in.valid = f3_ff.valid;
      f4_in.wr    = f3_ff.wr;
      f4_in.neg   = f3_ff.n[N_W-1] ^ f3_ff.h[16];
      f4_in.col   = (f3_ff.flip && (tex_width != '0)) ? tex_width - col_raw - 11'd1 : col_raw;
      f4_in.a     = f3_ff.n[N_W-1] ? n_neg[REM_W-1:0] : f3_ff.n[REM_W-1:0];
      f4_in.b     = f3_ff.h[16] ? 16'(-f3_ff.h) : f3_ff.h[15:0];
      f4_in.frame = f3_ff.frame;
   end

   always_comb begin
      f5_in.valid = f4_ff.valid;
      f5_in.wr    = f4_ff.wr;
      f5_in.neg   = f4_ff.neg;
      f5_in.sat   = f4_ff.a >= {1'b0, f4_ff.b, 19'd0};
      f5_in.rem   = f4_ff.a;
      f5_in.div   = f4_ff.b;
      f5_in.q     = '0;
      f5_in.col   = f4_ff.col;
      f5_in.frame = f4_ff.frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= '0;
         f2_ff <= '0;
         f3_ff <= '0;
         f4_ff <= '0;
         f5_ff <= '0;
      end else if (ce) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         f4_ff <= f4_in;
         f5_ff <= f5_in;
      end
   end

   assign div_out = f5_ff;

endmodule

`default_nettype wire

/* sv/wcm_div.sv */
// Restoring divider pipeline, one quotient bit per stage.
`default_nettype none

module wcm_div import wcm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  ce,
   input  wire wcm_div_type div_in,
   output wcm_div_type div_out
);

   wcm_div_type stg_src [QBITS];
   wcm_div_type stg_in  [QBITS];
   wcm_div_type stg_ff  [QBITS];

   assign stg_src[0] = div_in;

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      localparam int Bit = QBITS - 1 - k;

      logic [REM_W-1:0] sub_val;
      logic [REM_W:0]   diff;

      if (k > 0) begin : g_link
         assign stg_src[k] = stg_ff[k-1];
      end

      always_comb begin
         sub_val    = REM_W'(stg_src[k].div) << Bit;
         diff       = {1'b0, stg_src[k].rem} - {1'b0, sub_val};
         stg_in[k]  = stg_src[k];
         if (!diff[REM_W]) begin
            stg_in[k].rem    = diff[REM_W-1:0];
            stg_in[k].q[Bit] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k] <= '0;
         end else if (ce) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign div_out = stg_ff[QBITS-1];

endmodule

`default_nettype wire

/* sv/wcm_back.sv */
// Back stages: texture row clamp and texel index.
`default_nettype none

module wcm_back import wcm_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             ce,
   input  wire logic [TEX_W-1:0] tex_width,
   input  wire logic [TEX_W-1:0] tex_height,
   input  wire wcm_div_type      div_in,
   output wcm_rsp_type           result
);

   typedef struct packed {
      logic               valid;
      logic               wr;
      logic [TEX_W-1:0]   row;
      logic [TEX_W-1:0]   col;
      logic [FRAME_W-1:0] frame;
   } b1_type;

   b1_type      b1_ff, b1_in;
   wcm_rsp_type b2_ff, b2_in;

   logic [TEX_W-1:0]   q_hi;
   logic [2*TEX_W:0]   texel_sum;

   always_comb begin
      q_hi        = div_in.q[QBITS-1:QBITS-TEX_W];
      b1_in.valid = div_in.valid;
      b1_in.wr    = div_in.wr;
      b1_in.col   = div_in.col;
      b1_in.frame = div_in.frame;
      if ((tex_height == '0) || div_in.neg) begin
         b1_in.row = '0;
      end else if (div_in.sat || (q_hi >= tex_height)) begin
         b1_in.row = tex_height - 11'd1;
      end else begin
         b1_in.row = q_hi;
      end
   end

   always_comb begin
      texel_sum         = (2*TEX_W+1)'(b1_ff.row) * (2*TEX_W+1)'(tex_width)
                          + (2*TEX_W+1)'(b1_ff.col);
      b2_in.valid       = b1_ff.valid;
      b2_in.write_pixel = b1_ff.wr;
      b2_in.frame_index = b1_ff.frame;
      b2_in.texel_index = b1_ff.wr ? texel_sum[TEXEL_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_ff <= '0;
         b2_ff <= '0;
      end else if (ce) begin
         b1_ff <= b1_in;
         b2_ff <= b2_in;
      end
   end

   assign result = b2_ff;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for the wall column texel mapper: directed and random pixels checked against a texel predictor.
module testbench import wcm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W     = 640;
   localparam int SCREEN_H     = 480;
   localparam int DRAIN_CYCLES = 40;
   localparam int DRAIN_LIMIT  = 5000;

   typedef struct {
      logic signed [11:0] px;
      logic signed [15:0] py;
      logic signed [15:0] top;
      logic signed [15:0] bottom;
      logic               side;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] step_x;
      logic signed [31:0] step_y;
      logic        [30:0] wall_dist;
   } pixel_type;

   typedef struct {
      logic               write_pixel;
      logic [FRAME_W-1:0] frame_index;
      logic [TEXEL_W-1:0] texel_index;
   } texel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [11:0]        req_pixel_x = '0;
   logic [15:0]        req_pixel_y = '0;
   logic [15:0]        req_wall_top = '0;
   logic [15:0]        req_wall_bottom = '0;
   logic               req_hit_side = 1'b0;
   logic [31:0]        req_ray_origin_x = '0;
   logic [31:0]        req_ray_origin_y = '0;
   logic [31:0]        req_ray_step_x = '0;
   logic [31:0]        req_ray_step_y = '0;
   logic [30:0]        req_wall_distance = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_write_pixel;
   logic [FRAME_W-1:0] rsp_frame_index;
   logic [TEXEL_W-1:0] rsp_texel_index;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = 1'b0;
   logic [TEX_W-1:0]   csr_data = '0;

   int        tex_width = 64;
   int        tex_height = 64;
   texel_type pending_texels[$];
   int        mismatches = 0;
   int        send_gap_max = 17;
   int        sink_stall_max = 17;
   int        next_send_gap = 0;
   int        sink_wait = 0;
   bit        req_up = 1'b0;

   wall_column_texel_mapper_top #(
      .SCREEN_W(SCREEN_W),
      .SCREEN_H(SCREEN_H)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_wall_top(req_wall_top),
      .req_wall_bottom(req_wall_bottom),
      .req_hit_side(req_hit_side),
      .req_ray_origin_x(req_ray_origin_x),
      .req_ray_origin_y(req_ray_origin_y),
      .req_ray_step_x(req_ray_step_x),
      .req_ray_step_y(req_ray_step_y),
      .req_wall_distance(req_wall_distance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_write_pixel(rsp_write_pixel),
      .rsp_frame_index(rsp_frame_index),
      .rsp_texel_index(rsp_texel_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic texel_type map_texel(pixel_type p);
      texel_type   r;
      longint      span, depth, row, org, dir;
      logic [63:0] acc, col;
      bit          mirror;
      r = '{1'b0, '0, '0};
      span = longint'(p.bottom) - longint'(p.top);
      if (p.py < 0 || p.py >= SCREEN_H || p.px < 0 || p.px >= SCREEN_W || span == 0)
         return r;
      org = p.side ? longint'(p.origin_x) : longint'(p.origin_y);
      dir = p.side ? longint'(p.step_x) : longint'(p.step_y);
      acc = (org << 16) + longint'(p.wall_dist) * dir;
      col = ({32'b0, acc[31:0]} * 64'(tex_width)) >> 32;
      mirror = (!p.side && p.step_y > 0) || (p.side && p.step_x < 0);
      if (mirror && tex_width > 0)
         col = 64'(tex_width) - col - 64'd1;
      depth = longint'(p.py) * 256 - longint'(SCREEN_H) * 128 + span * 128;
      row = ((depth * tex_height) / span) / 256;
      if (row > tex_height - 1)
         row = tex_height - 1;
      if (row < 0)
         row = 0;
      r.write_pixel = 1'b1;
      r.frame_index = FRAME_W'(longint'(p.py) * SCREEN_W + longint'(p.px));
      r.texel_index = TEXEL_W'(row * tex_width + longint'(col));
      return r;
   endfunction

   function automatic logic signed [31:0] rand_signed(int unsigned magnitude);
      return $signed($urandom_range(0, 2 * magnitude) - magnitude);
   endfunction

   function automatic pixel_type make_pixel(logic signed [11:0] px, logic signed [15:0] py,
                                            logic signed [15:0] top,
                                            logic signed [15:0] bottom,
                                            logic side,
                                            logic signed [31:0] ox, logic signed [31:0] oy,
                                            logic signed [31:0] sx, logic signed [31:0] sy,
                                            logic [30:0] wall_dist);
      pixel_type p;
      p = '{px, py, top, bottom, side, ox, oy, sx, sy, wall_dist};
      return p;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      int        pick, span, centre;
      pick = $urandom_range(0, 99);
      p.side = 1'($urandom);
      p.origin_x = $urandom;
      p.origin_y = $urandom;
      if (pick < 12) begin
         // noise: every field at random
         p.px = 12'($urandom);
         p.py = 16'($urandom);
         p.top = 16'($urandom);
         p.bottom = 16'($urandom);
         p.step_x = $urandom;
         p.step_y = $urandom;
         p.wall_dist = 31'($urandom);
         return p;
      end
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4000) : $urandom_range(1, 600);
      centre = SCREEN_H / 2 + int'($urandom_range(0, 40)) - 20;
      p.top = 16'(centre - span / 2);
      p.bottom = 16'(int'(p.top) + span);
      if (pick < 18)
         p.bottom = p.top;
      else if (pick < 24)
         {p.top, p.bottom} = {p.bottom, p.top};
      if (pick < 30) begin
         p.px = 12'($urandom);
         p.py = 16'($urandom);
      end else begin
         p.px = 12'($urandom_range(0, SCREEN_W - 1));
         p.py = 16'($urandom_range(0, SCREEN_H - 1));
      end
      if ($urandom_range(0, 3) == 0) begin
         p.step_x = $urandom;
         p.step_y = $urandom;
         p.wall_dist = 31'($urandom);
      end else begin
         p.step_x = rand_signed(1 << 17);
         p.step_y = rand_signed(1 << 17);
         p.wall_dist = 31'($urandom_range(0, 1 << 22));
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic send_pixel(pixel_type p);
      repeat (next_send_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_up = 1'b1;
      req_pixel_x <= p.px;
      req_pixel_y <= p.py;
      req_wall_top <= p.top;
      req_wall_bottom <= p.bottom;
      req_hit_side <= p.side;
      req_ray_origin_x <= p.origin_x;
      req_ray_origin_y <= p.origin_y;
      req_ray_step_x <= p.step_x;
      req_ray_step_y <= p.step_y;
      req_wall_distance <= p.wall_dist;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_texels.push_back(map_texel(p));
      next_send_gap = $urandom_range(0, send_gap_max);
      if (next_send_gap != 0) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      while (pending_texels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_texture_size(int width, int height);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_TEXTURE_WIDTH;
      csr_data <= TEX_W'(width);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_index <= CSR_TEXTURE_HEIGHT;
      csr_data <= TEX_W'(height);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      tex_width = width & 'h7FF;
      tex_height = height & 'h7FF;
   endtask

   task automatic check_directed_edges();
      send_gap_max = 0;
      sink_stall_max = 0;
      next_send_gap = 0;
      send_pixel(make_pixel(0, 0, 0, 480, 1'b0, 0, 32'sh8000, 0, 0, 0));
      send_pixel(make_pixel(639, 479, 0, 480, 1'b1, 32'sh1_4000, 0, -32'sh1_0000, 0,
                            31'h1_0000));
      send_pixel(make_pixel(320, 240, 0, 480, 1'b0, 0, 32'sh2_3000, 0, 32'sh1_0000,
                            31'h8000));
      send_pixel(make_pixel(100, 100, 0, 480, 1'b1, 32'sh2_3000, 0, 32'sh1_0000, 0,
                            31'h8000));
      send_pixel(make_pixel(10, 200, 100, 100, 1'b0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(10, 200, 400, 100, 1'b0, 0, 32'sh1234, 0, 0, 0));
      send_pixel(make_pixel(50, 479, 200, 210, 1'b0, 0, 32'sh4000, 0, 0, 0));
      send_pixel(make_pixel(50, 0, 200, 210, 1'b1, 32'sh4000, 0, 0, 0, 0));
      send_pixel(make_pixel(5, 240, -32768, 32767, 1'b0, 0, 32'shC000, 0, 0, 0));
      send_pixel(make_pixel(5, 240, 32767, -32768, 1'b1, 32'shC000, 0, 0, 0, 0));
      send_pixel(make_pixel(-1, 0, 0, 480, 1'b0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(640, 0, 0, 480, 1'b0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(0, -1, 0, 480, 1'b0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(0, 480, 0, 480, 1'b0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(-2048, -32768, -32768, -32768, 1'b1, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF));
      send_pixel(make_pixel(2047, 32767, 32767, -1, 1'b0, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
      send_pixel(make_pixel(300, 300, 0, 480, 1'b0, 0, 32'sh7FFF_FFFF, 0,
                            32'sh8000_0000, 31'h7FFF_FFFF));
      send_pixel(make_pixel(300, 300, 0, 480, 1'b1, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0,
                            31'h7FFF_FFFF));
      send_pixel(make_pixel(639, 0, 0, 480, 1'b0, 0, -32'sh1, 0, 0, 0));
      send_pixel(make_pixel(0, 479, 0, 480, 1'b1, -32'sh1, 0, 32'sh1, 0, 31'h1));
      send_gap_max = 17;
      sink_stall_max = 17;
   endtask

   task automatic check_texture_sizes();
      int widths[10];
      int heights[10];
      widths = '{1, 1024, 0, 2047, 0, 64, 3, 1000, 0, 0};
      heights = '{1, 1024, 0, 2047, 64, 0, 1000, 3, 0, 0};
      widths[8] = $urandom_range(1, 1024);
      heights[8] = $urandom_range(1, 1024);
      widths[9] = $urandom_range(1, 1024);
      heights[9] = $urandom_range(1, 1024);
      foreach (widths[i]) begin
         set_texture_size(widths[i], heights[i]);
         repeat (30) send_pixel(random_pixel());
      end
   endtask

   task automatic check_random_stream();
      int width, height;
      for (int chunk = 0; chunk < 5; chunk++) begin
         width = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
         height = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
         set_texture_size(width, height);
         send_gap_max = (chunk % 2 == 0) ? 17 : 0;
         sink_stall_max = (chunk == 1 || chunk == 4) ? 0 : 17;
         repeat (50) send_pixel(random_pixel());
         // hold the sender until the pipeline is empty, then carry on
         wait_idle();
         repeat (50) send_pixel(random_pixel());
      end
      send_gap_max = 17;
      sink_stall_max = 17;
      set_texture_size(64, 64);
      repeat (30) send_pixel(random_pixel());
   endtask

   always @(posedge clock) begin
      texel_type got, want;
      if (reset) begin
         sink_wait = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_write_pixel, rsp_frame_index, rsp_texel_index};
            if (pending_texels.size() == 0) begin
               report_mismatch("unexpected transfer", got.frame_index, 0);
            end else begin
               want = pending_texels.pop_front();
               if (got.write_pixel !== want.write_pixel)
                  report_mismatch("write_pixel", got.write_pixel, want.write_pixel);
               if (got.frame_index !== want.frame_index)
                  report_mismatch("frame_index", got.frame_index, want.frame_index);
               if (got.texel_index !== want.texel_index)
                  report_mismatch("texel_index", got.texel_index, want.texel_index);
            end
            sink_wait = $urandom_range(0, sink_stall_max);
         end else if (sink_wait != 0) begin
            sink_wait--;
         end
         rsp_stall <= (sink_wait != 0);
      end
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      check_directed_edges();
      check_texture_sizes();
      check_random_stream();
      wait_idle();
      if (pending_texels.size() != 0)
         report_mismatch("results missing", pending_texels.size(), 0);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
